FILE: hw/rtl/atg_pkg.sv
package atg_pkg;

    localparam int IN_W   = 152;
    localparam int OUT_W  = 240;
    localparam int ADDR_W = 3;

    localparam logic [ADDR_W-1:0] ADDR_TICK_FREQ = 3'd0;
    localparam logic [19:0]       FREQ_RESET     = 20'd1000;
    localparam logic [23:0]       TILT_LIMIT     = 24'd5898240;

    localparam int ROOT_W  = 30;
    localparam int RAD_W   = 2 * ROOT_W;
    localparam int CORD_W  = 34;
    localparam int CORD_N  = 24;
    localparam int DIVD_W  = 61;
    localparam int DIVS_W  = 21;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_SQRT_GO,
        ST_SQRT_WAIT,
        ST_CORDIC_GO,
        ST_CORDIC_WAIT,
        ST_TILT,
        ST_GYRO_MUL,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_GYRO_ACC,
        ST_WRITE
    } state_t;

    // atan(2^-i) in 1/2^20 degree
    function automatic logic [25:0] atan_lut(input logic [4:0] idx);
        logic [25:0] v;
        case (idx)
            5'd0:    v = 26'd47185920;
            5'd1:    v = 26'd27855475;
            5'd2:    v = 26'd14718068;
            5'd3:    v = 26'd7471121;
            5'd4:    v = 26'd3750058;
            5'd5:    v = 26'd1876857;
            5'd6:    v = 26'd938658;
            5'd7:    v = 26'd469357;
            5'd8:    v = 26'd234682;
            5'd9:    v = 26'd117342;
            5'd10:   v = 26'd58671;
            5'd11:   v = 26'd29335;
            5'd12:   v = 26'd14668;
            5'd13:   v = 26'd7334;
            5'd14:   v = 26'd3667;
            5'd15:   v = 26'd1833;
            5'd16:   v = 26'd917;
            5'd17:   v = 26'd458;
            5'd18:   v = 26'd229;
            5'd19:   v = 26'd115;
            5'd20:   v = 26'd57;
            5'd21:   v = 26'd29;
            5'd22:   v = 26'd14;
            5'd23:   v = 26'd7;
            default: v = 26'd0;
        endcase
        return v;
    endfunction

endpackage

FILE: hw/rtl/atg_sqrt.sv
module atg_sqrt (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [atg_pkg::RAD_W-1:0]     radicand,
    output logic                          done,
    output logic [atg_pkg::ROOT_W-1:0]    root
);

    logic [atg_pkg::RAD_W-1:0]  rad_reg, rad_next;
    logic [atg_pkg::ROOT_W+2:0] rem_reg, rem_next;
    logic [atg_pkg::ROOT_W-1:0] root_reg, root_next;
    logic [4:0]                 cnt_reg, cnt_next;
    logic                       busy_reg, busy_next;
    logic                       done_reg, done_next;
    logic [atg_pkg::ROOT_W+2:0] rem_sh;
    logic [atg_pkg::ROOT_W+2:0] trial;

    always_comb begin
        rem_sh    = {rem_reg[atg_pkg::ROOT_W:0], rad_reg[atg_pkg::RAD_W-1 -: 2]};
        trial     = {1'b0, root_reg, 2'b01};
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rad_next  = radicand;
            rem_next  = '0;
            root_next = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rad_next = {rad_reg[atg_pkg::RAD_W-3:0], 2'b00};
            if (rem_sh >= trial) begin
                rem_next  = rem_sh - trial;
                root_next = {root_reg[atg_pkg::ROOT_W-2:0], 1'b1};
            end else begin
                rem_next  = rem_sh;
                root_next = {root_reg[atg_pkg::ROOT_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'(atg_pkg::ROOT_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

FILE: hw/rtl/atg_cordic.sv
module atg_cordic (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [atg_pkg::ROOT_W-1:0]  x_in,
    input  logic [atg_pkg::ROOT_W-1:0]  y_in,
    output logic                        done,
    output logic signed [31:0]          angle
);

    logic signed [atg_pkg::CORD_W-1:0] x_reg, x_next, y_reg, y_next, dx, dy;
    logic signed [31:0]                z_reg, z_next, step_angle;
    logic [4:0]                        i_reg, i_next;
    logic                              busy_reg, busy_next;
    logic                              done_reg, done_next;

    always_comb begin
        dx         = y_reg >>> i_reg;
        dy         = x_reg >>> i_reg;
        step_angle = 32'(atg_pkg::atan_lut(i_reg));
        x_next     = x_reg;
        y_next     = y_reg;
        z_next     = z_reg;
        i_next     = i_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        if (start) begin
            x_next    = atg_pkg::CORD_W'(x_in);
            y_next    = atg_pkg::CORD_W'(y_in);
            z_next    = '0;
            i_next    = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            // rotate towards the x axis
            if (!y_reg[atg_pkg::CORD_W-1]) begin
                x_next = x_reg + dx;
                y_next = y_reg - dy;
                z_next = z_reg + step_angle;
            end else begin
                x_next = x_reg - dx;
                y_next = y_reg + dy;
                z_next = z_reg - step_angle;
            end
            i_next = i_reg + 5'd1;
            if (i_reg == 5'(atg_pkg::CORD_N - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            i_reg    <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            i_reg    <= i_next;
        end
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
    end

    assign done  = done_reg;
    assign angle = z_reg;

endmodule

FILE: hw/rtl/atg_div.sv
module atg_div (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [atg_pkg::DIVD_W-1:0]  dividend,
    input  logic [atg_pkg::DIVS_W-1:0]  divisor,
    output logic                        done,
    output logic [atg_pkg::DIVD_W-1:0]  quotient
);

    logic [atg_pkg::DIVD_W-1:0] q_reg, q_next;
    logic [atg_pkg::DIVS_W-1:0] d_reg, d_next;
    logic [atg_pkg::DIVS_W-1:0] rem_reg, rem_next;
    logic [atg_pkg::DIVS_W:0]   rem_sh;
    logic [5:0]                 cnt_reg, cnt_next;
    logic                       busy_reg, busy_next;
    logic                       done_reg, done_next;

    always_comb begin
        rem_sh    = {rem_reg, q_reg[atg_pkg::DIVD_W-1]};
        q_next    = q_reg;
        d_next    = d_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            q_next    = dividend;
            d_next    = divisor;
            rem_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (rem_sh >= {1'b0, d_reg}) begin
                rem_next = atg_pkg::DIVS_W'(rem_sh - {1'b0, d_reg});
                q_next   = {q_reg[atg_pkg::DIVD_W-2:0], 1'b1};
            end else begin
                rem_next = rem_sh[atg_pkg::DIVS_W-1:0];
                q_next   = {q_reg[atg_pkg::DIVD_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'(atg_pkg::DIVD_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        q_reg   <= q_next;
        d_reg   <= d_next;
        rem_reg <= rem_next;
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

FILE: hw/rtl/accel_tilt_gyro_integrator.sv
// Tilt from a three-axis accelerometer and integrated gyro angles.
// s_axis: one sensor sample per transaction. m_axis: one result per sample,
// pitch/roll from the accelerometer, this sample's gyro steps and the three
// running gyro angle sums (angles in 1/65536 degree).
// APB: one register, tick_frequency at byte address 0, reset value 1000.
// Write it only while no sample is in flight.
// Each sample runs two 30-step square roots and two 24-step CORDIC passes,
// then three 61-step divisions for the gyro steps, all one after another on
// the iterative units, so a new sample is taken only after the previous one
// is through; s_tready is high only while the sequencer is idle.
// The result sits in an output register, so a new sample is taken while
// the previous result still waits; if the receiver stalls until the next
// result is ready, the sequencer holds at the write step until it drains.
// Reset clears the previous tick, the three angle sums and the handshakes,
// and restores tick_frequency to 1000.
module accel_tilt_gyro_integrator (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // accel_x, accel_y, accel_z, rate_x, rate_y, rate_z, tick_now
    input  logic [atg_pkg::IN_W-1:0]    s_tdata,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // pitch_accel, roll_accel, pitch_step, roll_step, yaw_step,
    // pitch_integrated, roll_integrated, yaw_integrated
    output logic [atg_pkg::OUT_W-1:0]   m_tdata,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [atg_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    atg_pkg::state_t state_reg, state_next;

    logic [19:0]        freq_reg;
    logic [31:0]        prev_tick_reg, tick_diff_reg;
    logic signed [15:0] ax_reg, ay_reg, az_reg;
    logic signed [23:0] rate_reg [3];
    logic [30:0]        sq_reg [3];
    logic [1:0]         cnt_reg, cnt_next;
    logic               tilt_sel_reg, tilt_sel_next;
    logic [29:0]        root_reg;
    logic signed [23:0] tilt_reg [2];
    logic [55:0]        prod_reg;
    logic signed [31:0] step_reg [3];
    logic signed [31:0] sum_reg [3];
    logic               m_tvalid_reg;
    logic [atg_pkg::OUT_W-1:0] m_tdata_reg;

    logic               in_fire, out_load, cfg_write;
    logic signed [15:0] sq_op;
    logic signed [31:0] sq_prod;
    logic signed [15:0] tilt_num;
    logic [15:0]        tilt_mag;
    logic [31:0]        sq_sum;
    logic               sqrt_start, sqrt_done, cord_start, cord_done, div_start, div_done;
    logic [29:0]        sqrt_root, cord_y;
    logic signed [31:0] cord_z, z_round;
    logic [23:0]        q_clamp;
    logic signed [23:0] tilt_val;
    logic signed [23:0] rate_cur;
    logic [23:0]        rate_mag;
    logic [19:0]        freq_eff;
    logic [60:0]        div_q;
    logic signed [31:0] step_val;
    logic signed [32:0] acc_wide;
    logic signed [31:0] acc_val;

    assign cfg_write = psel && penable && pwrite && (paddr == atg_pkg::ADDR_TICK_FREQ);
    assign pready    = 1'b1;
    assign prdata    = (paddr == atg_pkg::ADDR_TICK_FREQ) ? {12'd0, freq_reg} : 32'd0;

    assign s_tready = (state_reg == atg_pkg::ST_IDLE);
    assign in_fire  = s_tvalid && s_tready;
    assign out_load = (state_reg == atg_pkg::ST_WRITE) && (!m_tvalid_reg || m_tready);

    // shared squaring multiplier
    always_comb begin
        case (cnt_reg)
            2'd0:    sq_op = ax_reg;
            2'd1:    sq_op = ay_reg;
            default: sq_op = az_reg;
        endcase
        sq_prod = sq_op * sq_op;
    end

    always_comb begin
        tilt_num = tilt_sel_reg ? ax_reg : ay_reg;
        tilt_mag = tilt_num[15] ? 16'(-tilt_num) : 16'(tilt_num);
        sq_sum   = tilt_sel_reg ? 32'(sq_reg[1]) + 32'(sq_reg[2])
                                : 32'(sq_reg[0]) + 32'(sq_reg[2]);
        cord_y   = {tilt_mag, 14'd0};
        z_round  = (cord_z + 32'sd8) >>> 4;
        if (z_round[31])
            q_clamp = '0;
        else if (z_round > $signed({8'd0, atg_pkg::TILT_LIMIT}))
            q_clamp = atg_pkg::TILT_LIMIT;
        else
            q_clamp = z_round[23:0];
        if (tilt_mag == 16'd0)
            tilt_val = '0;
        else if (root_reg == 30'd0)
            tilt_val = tilt_num[15] ? -$signed(atg_pkg::TILT_LIMIT)
                                    : $signed(atg_pkg::TILT_LIMIT);
        else
            tilt_val = tilt_num[15] ? -$signed(q_clamp) : $signed(q_clamp);
    end

    always_comb begin
        case (cnt_reg)
            2'd0:    rate_cur = rate_reg[0];
            2'd1:    rate_cur = rate_reg[1];
            default: rate_cur = rate_reg[2];
        endcase
        rate_mag = rate_cur[23] ? 24'(-rate_cur) : 24'(rate_cur);
        freq_eff = (freq_reg == 20'd0) ? 20'd1 : freq_reg;
        if (!rate_cur[23])
            step_val = (div_q > 61'h7FFFFFFF) ? 32'sh7FFFFFFF : $signed(div_q[31:0]);
        else
            step_val = (div_q > 61'h80000000) ? 32'sh80000000 : -$signed(div_q[31:0]);
    end

    always_comb begin
        case (cnt_reg)
            2'd0:    acc_wide = 33'(sum_reg[0]) + 33'(step_val);
            2'd1:    acc_wide = 33'(sum_reg[1]) + 33'(step_val);
            default: acc_wide = 33'(sum_reg[2]) + 33'(step_val);
        endcase
        if (acc_wide > 33'sh07FFFFFFF)
            acc_val = 32'sh7FFFFFFF;
        else if (acc_wide < -33'sh080000000)
            acc_val = 32'sh80000000;
        else
            acc_val = acc_wide[31:0];
    end

    atg_sqrt u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (sqrt_start),
        .radicand ({sq_sum, 28'd0}),
        .done     (sqrt_done),
        .root     (sqrt_root)
    );

    atg_cordic u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cord_start),
        .x_in    (root_reg),
        .y_in    (cord_y),
        .done    (cord_done),
        .angle   (cord_z)
    );

    atg_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend ({prod_reg, 5'd0} + 61'(freq_eff)),
        .divisor  ({freq_eff, 1'b0}),
        .done     (div_done),
        .quotient (div_q)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= atg_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        tilt_sel_next = tilt_sel_reg;
        sqrt_start    = 1'b0;
        cord_start    = 1'b0;
        div_start     = 1'b0;
        case (state_reg)
            atg_pkg::ST_IDLE: begin
                if (in_fire) begin
                    state_next    = atg_pkg::ST_SQUARE;
                    cnt_next      = '0;
                    tilt_sel_next = 1'b0;
                end
            end
            atg_pkg::ST_SQUARE: begin
                cnt_next = cnt_reg + 2'd1;
                if (cnt_reg == 2'd2)
                    state_next = atg_pkg::ST_SQRT_GO;
            end
            atg_pkg::ST_SQRT_GO: begin
                sqrt_start = 1'b1;
                state_next = atg_pkg::ST_SQRT_WAIT;
            end
            atg_pkg::ST_SQRT_WAIT: begin
                if (sqrt_done)
                    state_next = atg_pkg::ST_CORDIC_GO;
            end
            atg_pkg::ST_CORDIC_GO: begin
                cord_start = 1'b1;
                state_next = atg_pkg::ST_CORDIC_WAIT;
            end
            atg_pkg::ST_CORDIC_WAIT: begin
                if (cord_done)
                    state_next = atg_pkg::ST_TILT;
            end
            atg_pkg::ST_TILT: begin
                if (tilt_sel_reg) begin
                    state_next = atg_pkg::ST_GYRO_MUL;
                    cnt_next   = '0;
                end else begin
                    tilt_sel_next = 1'b1;
                    state_next    = atg_pkg::ST_SQRT_GO;
                end
            end
            atg_pkg::ST_GYRO_MUL: begin
                state_next = atg_pkg::ST_DIV_GO;
            end
            atg_pkg::ST_DIV_GO: begin
                div_start  = 1'b1;
                state_next = atg_pkg::ST_DIV_WAIT;
            end
            atg_pkg::ST_DIV_WAIT: begin
                if (div_done)
                    state_next = atg_pkg::ST_GYRO_ACC;
            end
            atg_pkg::ST_GYRO_ACC: begin
                cnt_next = cnt_reg + 2'd1;
                if (cnt_reg == 2'd2)
                    state_next = atg_pkg::ST_WRITE;
                else
                    state_next = atg_pkg::ST_GYRO_MUL;
            end
            atg_pkg::ST_WRITE: begin
                if (out_load)
                    state_next = atg_pkg::ST_IDLE;
            end
            default: begin
                state_next = atg_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            freq_reg      <= atg_pkg::FREQ_RESET;
            prev_tick_reg <= '0;
            sum_reg[0]    <= '0;
            sum_reg[1]    <= '0;
            sum_reg[2]    <= '0;
            m_tvalid_reg  <= 1'b0;
            cnt_reg       <= '0;
            tilt_sel_reg  <= 1'b0;
        end else begin
            cnt_reg      <= cnt_next;
            tilt_sel_reg <= tilt_sel_next;
            if (cfg_write)
                freq_reg <= pwdata[19:0];
            if (in_fire)
                prev_tick_reg <= s_tdata[151:120];
            if (state_reg == atg_pkg::ST_GYRO_ACC) begin
                case (cnt_reg)
                    2'd0:    sum_reg[0] <= acc_val;
                    2'd1:    sum_reg[1] <= acc_val;
                    default: sum_reg[2] <= acc_val;
                endcase
            end
            if (out_load)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
        end
        if (in_fire) begin
            ax_reg        <= s_tdata[15:0];
            ay_reg        <= s_tdata[31:16];
            az_reg        <= s_tdata[47:32];
            rate_reg[0]   <= s_tdata[71:48];
            rate_reg[1]   <= s_tdata[95:72];
            rate_reg[2]   <= s_tdata[119:96];
            tick_diff_reg <= s_tdata[151:120] - prev_tick_reg;
        end
        if (state_reg == atg_pkg::ST_SQUARE) begin
            case (cnt_reg)
                2'd0:    sq_reg[0] <= sq_prod[30:0];
                2'd1:    sq_reg[1] <= sq_prod[30:0];
                default: sq_reg[2] <= sq_prod[30:0];
            endcase
        end
        if (sqrt_done)
            root_reg <= sqrt_root;
        if (state_reg == atg_pkg::ST_TILT) begin
            if (tilt_sel_reg)
                tilt_reg[1] <= tilt_val;
            else
                tilt_reg[0] <= tilt_val;
        end
        if (state_reg == atg_pkg::ST_GYRO_MUL)
            prod_reg <= rate_mag * tick_diff_reg;
        if (state_reg == atg_pkg::ST_GYRO_ACC) begin
            case (cnt_reg)
                2'd0:    step_reg[0] <= step_val;
                2'd1:    step_reg[1] <= step_val;
                default: step_reg[2] <= step_val;
            endcase
        end
        if (out_load)
            m_tdata_reg <= {sum_reg[2], sum_reg[1], sum_reg[0],
                            step_reg[2], step_reg[1], step_reg[0],
                            tilt_reg[1], tilt_reg[0]};
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire |=> !s_tready)
        else $error("input taken while a sample is in flight");

    a_load_sets_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> m_tvalid)
        else $error("result load lost");

    a_pitch_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ($signed(m_tdata[23:0]) <= $signed(atg_pkg::TILT_LIMIT)
                   && $signed(m_tdata[23:0]) >= -$signed(atg_pkg::TILT_LIMIT)))
        else $error("pitch out of range");

endmodule
